>>> rtl/tsw_pkg.sv
// Package for the wrapping bilinear texture sampler: shared codes, widths and
// the texel index wrap function. Depends on nothing.
package tsw_pkg;

    localparam int COORD_W = 24;
    localparam int CHAN_W  = 16;
    localparam int TEXEL_W = 4 * CHAN_W;
    localparam int SIZE_W  = 8;
    localparam int PROD_W  = 25;

    localparam logic [0:0] OP_WRITE  = 1'b0;
    localparam logic [0:0] OP_SAMPLE = 1'b1;

    localparam logic [1:0] WRAP_CLAMP  = 2'd0;
    localparam logic [1:0] WRAP_MIRROR = 2'd1;
    localparam logic [1:0] WRAP_REPEAT = 2'd2;

    localparam logic [0:0] FILTER_NEAREST  = 1'b0;
    localparam logic [0:0] FILTER_BILINEAR = 1'b1;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_WRAP_S = 3'd2;
    localparam logic [2:0] REG_WRAP_T = 3'd3;
    localparam logic [2:0] REG_FILTER = 3'd4;

    typedef logic [TEXEL_W-1:0] t_texel;

    // Wrap an index in [-1, count] into [0, count-1]. Over that range mirrored
    // repeat gives the same answer as clamp to edge.
    function automatic logic [SIZE_W-1:0] wrap_idx(input logic signed [9:0] value,
                                                   input logic [SIZE_W-1:0] count,
                                                   input logic [1:0] mode);
        logic edge_like;
        edge_like = (mode == WRAP_CLAMP) || (mode == WRAP_MIRROR);
        if (value < 10'sd0) begin
            wrap_idx = edge_like ? '0 : count - 8'd1;
        end else if (value >= $signed({2'b00, count})) begin
            wrap_idx = edge_like ? count - 8'd1 : '0;
        end else begin
            wrap_idx = value[SIZE_W-1:0];
        end
    endfunction

endpackage

>>> rtl/tsw_if.sv
// Handshake interfaces of the texture sampler: input word, result word and
// configuration write. Depends on tsw_pkg.
interface tsw_in_if import tsw_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [13:0]                texel_address;
    logic [CHAN_W-1:0]          write_red;
    logic [CHAN_W-1:0]          write_green;
    logic [CHAN_W-1:0]          write_blue;
    logic [CHAN_W-1:0]          write_alpha;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;
    modport source (output valid, operation, texel_address, write_red, write_green,
                    write_blue, write_alpha, coord_u, coord_v, input ready);
    modport sink   (input valid, operation, texel_address, write_red, write_green,
                    write_blue, write_alpha, coord_u, coord_v, output ready);
endinterface

interface tsw_out_if import tsw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] sample_red;
    logic [CHAN_W-1:0] sample_green;
    logic [CHAN_W-1:0] sample_blue;
    logic [CHAN_W-1:0] sample_alpha;
    modport source (output valid, sample_red, sample_green, sample_blue, sample_alpha,
                    input ready);
    modport sink   (input valid, sample_red, sample_green, sample_blue, sample_alpha,
                    output ready);
endinterface

interface tsw_cfg_if import tsw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        index;
    logic [SIZE_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tsw_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module tsw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                      i_wdata,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> rtl/tsw_coord.sv
// Shared coordinate unit: wraps a Q8.16 coordinate into [0, 1.0] and scales it
// by the texture side. Depends on tsw_pkg.
module tsw_coord import tsw_pkg::*; (
    input  logic [COORD_W-1:0] i_raw,
    input  logic [1:0]         i_mode,
    input  logic [SIZE_W-1:0]  i_size,
    output logic [PROD_W-1:0]  o_prod
);
    logic [16:0] w;

    always_comb begin
        case (i_mode)
            WRAP_CLAMP: begin
                if (i_raw[COORD_W-1]) begin
                    w = '0;
                end else if (i_raw > 24'h010000) begin
                    w = 17'h10000;
                end else begin
                    w = i_raw[16:0];
                end
            end
            WRAP_MIRROR: w = i_raw[16] ? 17'h10000 - {1'b0, i_raw[15:0]} : {1'b0, i_raw[15:0]};
            default:     w = {1'b0, i_raw[15:0]};
        endcase
    end

    assign o_prod = PROD_W'(w) * PROD_W'(i_size);
endmodule

>>> rtl/tsw_lerp.sv
// Shared four-channel linear interpolation with 16 fractional weight bits and
// rounding. Depends on tsw_pkg.
module tsw_lerp import tsw_pkg::*; (
    input  t_texel            i_a,
    input  t_texel            i_b,
    input  logic [CHAN_W-1:0] i_t,
    output t_texel            o_mix
);
    for (genvar ch = 0; ch < 4; ch++) begin : g_chan
        logic signed [16:0] diff;
        logic signed [34:0] prod;
        logic signed [18:0] step;
        logic signed [18:0] sum;
        assign diff = $signed({1'b0, i_b[ch*CHAN_W +: CHAN_W]})
                    - $signed({1'b0, i_a[ch*CHAN_W +: CHAN_W]});
        assign prod = 35'(diff) * 35'($signed({1'b0, i_t})) + 35'sd32768;
        assign step = prod[34:16];
        assign sum  = $signed({3'b000, i_a[ch*CHAN_W +: CHAN_W]}) + step;
        assign o_mix[ch*CHAN_W +: CHAN_W] = sum[CHAN_W-1:0];
    end
endmodule

>>> rtl/texture_sampler_wrap_bilinear_unit.sv
// Top level of the wrapping bilinear texture sampler.
// Depends on tsw_pkg, the tsw interfaces, tsw_ram, tsw_coord and tsw_lerp.

// A write word stores one RGBA texel in the texel memory, and the block
// stays ready for the next word. A sample word, once accepted, is worked on
// in steps: the shared coordinate unit (u, then v), forming the texel
// indices, the four reads of the single-port texel memory and its registered
// output, and three passes through the shared interpolation unit. The result
// is then handed to the output register; the result word is offered, and the
// block is ready for the next word, in the same cycle. With a zero width or
// height the fetch and interpolation are skipped and the zero result is
// handed over once the indices are formed. Nearest filtering runs the full
// sequence with zero weights. The output register holds a result word until
// it is taken, and the block keeps accepting words meanwhile; a further
// sample finishes its work and then waits, and only then does the block stop
// accepting input. Configuration writes are always taken and must only be
// made while no sample is being worked on and no result word is waiting.
// Texels must be written before they are sampled.
module texture_sampler_wrap_bilinear_unit import tsw_pkg::*; #(
    parameter int TEXEL_DEPTH = 16384
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsw_in_if.sink    i_in,
    tsw_out_if.source o_out,
    tsw_cfg_if.sink   i_cfg
);
    localparam int AW = TEXEL_DEPTH > 1 ? $clog2(TEXEL_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CU    = 3'd1;
    localparam logic [2:0] ST_CV    = 3'd2;
    localparam logic [2:0] ST_IDX   = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;
    localparam logic [2:0] ST_LERP  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] r_state;

    // Configuration registers.
    logic [SIZE_W-1:0] r_width, r_height;
    logic [1:0]        r_wrap_s, r_wrap_t;
    logic              r_filter;

    // Sample working registers.
    logic [COORD_W-1:0] r_u, r_v;
    logic [PROD_W-1:0]  r_pu, r_pv;
    logic [SIZE_W-1:0]  r_x0, r_x1, r_y0, r_y1;
    logic [CHAN_W-1:0]  r_ds, r_dt;
    logic [2:0]         r_fcnt;
    logic [1:0]         r_lcnt;
    logic               r_oob_q;
    t_texel             r_c [4];
    t_texel             r_a, r_b, r_res;

    // Output register: a finished result waits here so that the sequencer can
    // go back to taking words.
    t_texel             r_out;
    logic               r_out_valid;
    logic               out_load;

    logic in_accept;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);

    // Shared coordinate unit: u in state ST_CU, then v in state ST_CV.
    logic [PROD_W-1:0] coord_prod;
    logic              sel_v;
    assign sel_v = (r_state == ST_CV);

    tsw_coord u_coord (
        .i_raw  (sel_v ? r_v : r_u),
        .i_mode (sel_v ? r_wrap_t : r_wrap_s),
        .i_size (sel_v ? r_height : r_width),
        .o_prod (coord_prod)
    );

    // Index forming: position minus half a texel, split into integer and
    // fraction; nearest takes the floor of the scaled coordinate clamped to
    // the last texel.
    logic signed [25:0] s_pos, t_pos;
    logic signed [9:0]  s0, t0, s1, t1;
    logic [8:0]         near_x, near_y;
    logic [SIZE_W-1:0]  near_xc, near_yc;

    always_comb begin
        s_pos   = $signed({1'b0, r_pu}) - 26'sd32768;
        t_pos   = $signed({1'b0, r_pv}) - 26'sd32768;
        s0      = s_pos[25:16];
        t0      = t_pos[25:16];
        s1      = s0 + 10'sd1;
        t1      = t0 + 10'sd1;
        near_x  = r_pu[24:16];
        near_y  = r_pv[24:16];
        near_xc = (near_x > {1'b0, r_width - 8'd1})  ? r_width - 8'd1  : near_x[7:0];
        near_yc = (near_y > {1'b0, r_height - 8'd1}) ? r_height - 8'd1 : near_y[7:0];
    end

    // Fetch address: row times width plus column, out of range reads zero.
    logic [SIZE_W-1:0] fx, fy;
    logic [16:0]       faddr;
    logic              f_oob;
    logic              w_oob;
    logic [AW-1:0]     ram_addr;
    logic              ram_we;
    t_texel            ram_q;

    always_comb begin
        fx    = r_fcnt[0] ? r_x1 : r_x0;
        fy    = r_fcnt[1] ? r_y1 : r_y0;
        faddr = 17'(16'(fy) * 16'(r_width)) + 17'(fx);
        f_oob = 32'(faddr) >= 32'(TEXEL_DEPTH);
        w_oob = 32'(i_in.texel_address) >= 32'(TEXEL_DEPTH);
        if (r_state == ST_IDLE) begin
            ram_addr = AW'(32'(i_in.texel_address));
        end else begin
            ram_addr = AW'(32'(faddr));
        end
        ram_we = in_accept && (i_in.operation == OP_WRITE) && !w_oob;
    end

    tsw_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (TEXEL_DEPTH)
    ) u_texel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_in.write_alpha, i_in.write_blue, i_in.write_green, i_in.write_red}),
        .o_rdata (ram_q)
    );

    // Shared interpolation unit: two passes along u, then one along v.
    t_texel            lerp_a, lerp_b, lerp_mix;
    logic [CHAN_W-1:0] lerp_t;

    always_comb begin
        case (r_lcnt)
            2'd0:    begin lerp_a = r_c[0]; lerp_b = r_c[1]; lerp_t = r_ds; end
            2'd1:    begin lerp_a = r_c[2]; lerp_b = r_c[3]; lerp_t = r_ds; end
            default: begin lerp_a = r_a;    lerp_b = r_b;    lerp_t = r_dt; end
        endcase
    end

    tsw_lerp u_lerp (
        .i_a   (lerp_a),
        .i_b   (lerp_b),
        .i_t   (lerp_t),
        .o_mix (lerp_mix)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_wrap_s <= WRAP_REPEAT;
            r_wrap_t <= WRAP_REPEAT;
            r_filter <= FILTER_BILINEAR;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_WIDTH:  r_width  <= i_cfg.data;
                REG_HEIGHT: r_height <= i_cfg.data;
                REG_WRAP_S: r_wrap_s <= i_cfg.data[1:0];
                REG_WRAP_T: r_wrap_t <= i_cfg.data[1:0];
                REG_FILTER: r_filter <= i_cfg.data[0];
                default:    ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fcnt  <= '0;
            r_lcnt  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept && i_in.operation == OP_SAMPLE) begin
                        r_state <= ST_CU;
                    end
                end
                ST_CU:  r_state <= ST_CV;
                ST_CV:  r_state <= ST_IDX;
                ST_IDX: begin
                    r_fcnt  <= '0;
                    r_lcnt  <= '0;
                    r_state <= (r_width == '0 || r_height == '0) ? ST_OUT : ST_FETCH;
                end
                ST_FETCH: begin
                    r_fcnt <= r_fcnt + 3'd1;
                    if (r_fcnt == 3'd4) begin
                        r_state <= ST_LERP;
                    end
                end
                ST_LERP: begin
                    r_lcnt <= r_lcnt + 2'd1;
                    if (r_lcnt == 2'd2) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The output register is full from the hand-over until the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_u <= i_in.coord_u;
            r_v <= i_in.coord_v;
        end
        if (r_state == ST_CU) r_pu <= coord_prod;
        if (r_state == ST_CV) r_pv <= coord_prod;
        if (r_state == ST_IDX) begin
            r_res <= '0;
            if (r_filter == FILTER_NEAREST) begin
                r_x0 <= near_xc;
                r_x1 <= near_xc;
                r_y0 <= near_yc;
                r_y1 <= near_yc;
                r_ds <= '0;
                r_dt <= '0;
            end else begin
                r_x0 <= wrap_idx(s0, r_width, r_wrap_s);
                r_x1 <= wrap_idx(s1, r_width, r_wrap_s);
                r_y0 <= wrap_idx(t0, r_height, r_wrap_t);
                r_y1 <= wrap_idx(t1, r_height, r_wrap_t);
                r_ds <= s_pos[15:0];
                r_dt <= t_pos[15:0];
            end
        end
        if (r_state == ST_FETCH) begin
            r_oob_q <= f_oob;
            if (r_fcnt != 3'd0) begin
                r_c[2'(r_fcnt - 3'd1)] <= r_oob_q ? '0 : ram_q;
            end
        end
        if (r_state == ST_LERP) begin
            case (r_lcnt)
                2'd0:    r_a   <= lerp_mix;
                2'd1:    r_b   <= lerp_mix;
                default: r_res <= lerp_mix;
            endcase
        end
        if (out_load) r_out <= r_res;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample_red   = r_out[0*CHAN_W +: CHAN_W];
    assign o_out.sample_green = r_out[1*CHAN_W +: CHAN_W];
    assign o_out.sample_blue  = r_out[2*CHAN_W +: CHAN_W];
    assign o_out.sample_alpha = r_out[3*CHAN_W +: CHAN_W];
endmodule

>>> tb/tb_texture_sampler_wrap_bilinear_unit.sv
// Testbench for texture_sampler_wrap_bilinear_unit: texel writes and samples under
// several texture sizes, wrap modes and filters, checked against an in-bench predictor.
// Depends on tsw_pkg, the tsw interfaces and the RTL top level.
`timescale 1ns / 1ps

module tb_texture_sampler_wrap_bilinear_unit;
    import tsw_pkg::*;

    localparam int MEM_DEPTH    = 16384;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_WAIT  = 30;
    localparam int LONG_HOLD    = 400;
    localparam int Q16_ONE      = 65536;
    localparam int Q16_HALF     = 32768;

    // One input word as the sender sees it.
    typedef struct {
        logic [0:0]               op;
        logic [13:0]              addr;
        t_texel                   texel;
        logic [COORD_W-1:0]       u;
        logic [COORD_W-1:0]       v;
    } t_sampler_word;

    // The scoreboard keeps its own texel store and register copies, predicts the
    // result of every accepted sample word and checks each result word in order.
    class sampler_scoreboard;
        t_texel           texels [MEM_DEPTH];
        int unsigned      tex_w;
        int unsigned      tex_h;
        logic [1:0]       wrap_s;
        logic [1:0]       wrap_t;
        logic [0:0]       filter;
        t_texel           expected_texels [$];
        int               mismatches;
        int               samples_seen;
        int               writes_seen;

        function void clear();
            foreach (texels[i]) texels[i] = '0;
            tex_w = 0;
            tex_h = 0;
            wrap_s = WRAP_REPEAT;
            wrap_t = WRAP_REPEAT;
            filter = FILTER_BILINEAR;
            mismatches = 0;
            samples_seen = 0;
            writes_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [SIZE_W-1:0] data);
            case (idx)
                REG_WIDTH:  tex_w  = data;
                REG_HEIGHT: tex_h  = data;
                REG_WRAP_S: wrap_s = data[1:0];
                REG_WRAP_T: wrap_t = data[1:0];
                REG_FILTER: filter = data[0];
                default: ;
            endcase
        endfunction

        // Maps a raw Q8.16 coordinate into [0, 1.0].
        function int unsigned fold_coord(logic [COORD_W-1:0] raw, logic [1:0] mode);
            int unsigned frac;
            frac = raw[15:0];
            if (mode == WRAP_CLAMP) begin
                if (raw[COORD_W-1]) return 0;
                return (raw > Q16_ONE) ? Q16_ONE : raw;
            end
            if (mode == WRAP_MIRROR) return raw[16] ? Q16_ONE - frac : frac;
            return frac;
        endfunction

        function int fold_index(int value, int count, logic [1:0] mode);
            int period;
            int r;
            if (mode == WRAP_CLAMP) begin
                if (value < 0) return 0;
                return (value > count - 1) ? count - 1 : value;
            end
            if (mode == WRAP_MIRROR) begin
                period = count * 2;
                r = value % period;
                if (r < 0) r += period;
                return (r < count) ? r : period - 1 - r;
            end
            r = value % count;
            if (r < 0) r += count;
            return r;
        endfunction

        function t_texel texel_at(int x, int y);
            int unsigned idx;
            idx = fold_index(y, tex_h, wrap_t) * tex_w + fold_index(x, tex_w, wrap_s);
            return (idx >= MEM_DEPTH) ? '0 : texels[idx];
        endfunction

        function t_texel blend(t_texel a, t_texel b, int unsigned wt);
            t_texel res;
            longint unsigned ca;
            longint unsigned cb;
            longint unsigned mix;
            res = '0;
            for (int ch = 0; ch < 4; ch++) begin
                ca = a[16*ch +: 16];
                cb = b[16*ch +: 16];
                mix = (ca * (Q16_ONE - wt) + cb * wt + Q16_HALF) >> 16;
                res[16*ch +: 16] = mix[15:0];
            end
            return res;
        endfunction

        function t_texel filtered_texel(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
            int unsigned wu;
            int unsigned wv;
            int unsigned x;
            int unsigned y;
            int s;
            int t;
            int s0;
            int t0;
            int unsigned ds;
            int unsigned dt;
            wu = fold_coord(u, wrap_s);
            wv = fold_coord(v, wrap_t);
            if (tex_w == 0 || tex_h == 0) return '0;
            if (filter == FILTER_NEAREST) begin
                x = (wu * tex_w) >> 16;
                y = (wv * tex_h) >> 16;
                if (x > tex_w - 1) x = tex_w - 1;
                if (y > tex_h - 1) y = tex_h - 1;
                return texel_at(x, y);
            end
            if (tex_w == 1 && tex_h == 1) return texels[0];
            s = int'(wu * tex_w) - Q16_HALF;
            t = int'(wv * tex_h) - Q16_HALF;
            s0 = (s >= 0) ? s / Q16_ONE : -1;
            t0 = (t >= 0) ? t / Q16_ONE : -1;
            ds = (s + Q16_ONE) & 32'hFFFF;
            dt = (t + Q16_ONE) & 32'hFFFF;
            return blend(blend(texel_at(s0, t0), texel_at(s0 + 1, t0), ds),
                         blend(texel_at(s0, t0 + 1), texel_at(s0 + 1, t0 + 1), ds), dt);
        endfunction

        function void note_word(t_sampler_word w);
            if (w.op == OP_WRITE) begin
                texels[w.addr] = w.texel;
                writes_seen++;
            end else begin
                expected_texels = {expected_texels, filtered_texel(w.u, w.v)};
                samples_seen++;
            end
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_word(t_texel got);
            t_texel want;
            if (expected_texels.size() == 0) begin
                report("unexpected result word, red", got[15:0], 0);
            end else begin
                want = expected_texels.pop_front();
                if (got[15:0]  != want[15:0])  report("red",   got[15:0],  want[15:0]);
                if (got[31:16] != want[31:16]) report("green", got[31:16], want[31:16]);
                if (got[47:32] != want[47:32]) report("blue",  got[47:32], want[47:32]);
                if (got[63:48] != want[63:48]) report("alpha", got[63:48], want[63:48]);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    tsw_in_if  in_if();
    tsw_out_if out_if();
    tsw_cfg_if cfg_if();

    texture_sampler_wrap_bilinear_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    sampler_scoreboard sb;

    // Idling percentages for each side; changed per phase by the stimulus.
    int send_idle_pct = 27;
    int recv_idle_pct = 65;
    // Requests for a long receiver hold-off; the receiver serves them itself.
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int unsigned cycle_count = 0;
    int phases_run = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested,
    // so that finished result words pile up at the output and block the input side.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            out_if.ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_served <= hold_requests;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Results are sampled at the edge, so the values seen are those before it.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_word({out_if.sample_alpha, out_if.sample_blue,
                           out_if.sample_green, out_if.sample_red});
        end
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_texture_sampler_wrap_bilinear_unit: errors");
            $finish;
        end
    end

    // Offers one word and waits for it to be taken. Valid is left high so that
    // a following word can go straight out in the next cycle.
    task send_word(t_sampler_word w);
        in_if.valid         <= 1'b1;
        in_if.operation     <= w.op;
        in_if.texel_address <= w.addr;
        in_if.write_red     <= w.texel[15:0];
        in_if.write_green   <= w.texel[31:16];
        in_if.write_blue    <= w.texel[47:32];
        in_if.write_alpha   <= w.texel[63:48];
        in_if.coord_u       <= w.u;
        in_if.coord_v       <= w.v;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(w);
    endtask

    // Sends a word and then perhaps leaves a gap, according to the sender's idling.
    task send_paced(t_sampler_word w);
        send_word(w);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every expected result has arrived, then lets
    // the block settle.
    task drain_block();
        in_if.valid <= 1'b0;
        while (sb.expected_texels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task write_reg(logic [2:0] idx, logic [SIZE_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_reg(idx, data);
    endtask

    task configure(int w, int h, logic [1:0] ws, logic [1:0] wt, logic [0:0] f);
        drain_block();
        write_reg(REG_WIDTH, SIZE_W'(w));
        write_reg(REG_HEIGHT, SIZE_W'(h));
        write_reg(REG_WRAP_S, {6'd0, ws});
        write_reg(REG_WRAP_T, {6'd0, wt});
        write_reg(REG_FILTER, {7'd0, f});
        cfg_if.valid <= 1'b0;
        phases_run++;
    endtask

    // Channel values lean towards the extremes now and then.
    function logic [15:0] rand_chan();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function t_sampler_word write_word(int addr);
        t_sampler_word w;
        w.op = OP_WRITE;
        w.addr = 14'(addr);
        w.texel = {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
        w.u = COORD_W'($urandom);
        w.v = COORD_W'($urandom);
        return w;
    endfunction

    function t_sampler_word sample_word(int u, int v);
        t_sampler_word w;
        w.op = OP_SAMPLE;
        w.addr = 14'($urandom);
        w.texel = {$urandom, $urandom};
        w.u = COORD_W'(u);
        w.v = COORD_W'(v);
        return w;
    endfunction

    // Coordinates mostly within a few repeats of the texture, sometimes anywhere.
    function int rand_coord();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3:       return ($urandom_range(0, 8) - 4) * Q16_HALF;
            default: return $urandom_range(0, 6 * Q16_ONE) - 3 * Q16_ONE;
        endcase
    endfunction

    // Every texel that a sample can reach is written before any sample is sent.
    task fill_texture();
        for (int a = 0; a < sb.tex_w * sb.tex_h; a++) send_paced(write_word(a));
    endtask

    task random_words(int count);
        int area;
        area = sb.tex_w * sb.tex_h;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 70) begin
                send_paced(sample_word(rand_coord(), rand_coord()));
            end else if (area > 0 && $urandom_range(4) != 0) begin
                send_paced(write_word($urandom_range(0, area - 1)));
            end else begin
                send_paced(write_word($urandom_range(0, MEM_DEPTH - 1)));
            end
        end
    endtask

    initial begin
        int pw;
        int ph;
        // Every input of the block starts at a known value.
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.operation = OP_WRITE;
        in_if.texel_address = '0;
        in_if.write_red = '0;
        in_if.write_green = '0;
        in_if.write_blue = '0;
        in_if.write_alpha = '0;
        in_if.coord_u = '0;
        in_if.coord_v = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_WIDTH;
        cfg_if.data = '0;
        sb = new();
        sb.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Straight after reset the size is zero, so samples come back as zero.
        send_paced(sample_word(24'h000000, 24'h000000));
        send_paced(sample_word(24'h7FFFFF, 24'h800000));

        // Small texture, clamp on u and mirror on v, bilinear: the coordinate
        // extremes, exact edges and the half-texel points.
        configure(2, 2, WRAP_CLAMP, WRAP_MIRROR, FILTER_BILINEAR);
        send_paced(write_word(0));
        send_paced(write_word(1));
        send_paced(write_word(2));
        send_paced(write_word(3));
        send_paced(write_word(MEM_DEPTH - 1));
        send_paced(write_word(14'h2AAA));
        send_paced(write_word(14'h1555));
        send_paced(sample_word(24'h000000, 24'h000000));
        send_paced(sample_word(24'h7FFFFF, 24'h7FFFFF));
        send_paced(sample_word(24'h800000, 24'h800000));
        send_paced(sample_word(24'h010000, 24'h010000));
        send_paced(sample_word(24'h008000, 24'hFF8000));
        send_paced(sample_word(24'hFFFFFF, 24'h01FFFF));

        // One by one texture under bilinear filtering returns its only texel.
        configure(1, 1, WRAP_REPEAT, WRAP_CLAMP, FILTER_BILINEAR);
        send_paced(sample_word(24'h004000, 24'hFFC000));

        // Wrap code three behaves as repeat; nearest filtering at the edges.
        configure(3, 2, 2'd3, 2'd3, FILTER_NEAREST);
        fill_texture();
        send_paced(sample_word(24'h00FFFF, 24'hFF0000));
        send_paced(sample_word(24'h7FFFFF, 24'h010000));
        send_paced(sample_word(24'h800000, 24'h000000));

        // Random phases: the first four with a lazy receiver, the next three with
        // a lazy sender, the last three with neither idling.
        for (int p = 0; p < 10; p++) begin
            if (p < 4) begin
                send_idle_pct = 27;
                recv_idle_pct = 65;
            end else if (p < 7) begin
                send_idle_pct = 65;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: begin pw = 128; ph = 2;   end
                1: begin pw = 2;   ph = 128; end
                2: begin pw = 0;   ph = 5;   end
                3: begin pw = 7;   ph = 0;   end
                9: begin pw = 1;   ph = 1;   end
                default: begin
                    pw = $urandom_range(1, 8);
                    ph = $urandom_range(1, 8);
                end
            endcase
            configure(pw, ph, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      (p == 0 || p == 1) ? p[0:0] : 1'($urandom_range(0, 1)));
            fill_texture();
            if (p == 5) hold_requests++;
            random_words(40);
        end

        drain_block();
        $display("Covered %0d texel writes and %0d samples over %0d register settings,",
                 sb.writes_seen, sb.samples_seen, phases_run);
        $display("with all wrap codes, both filters, zero and extreme texture sizes.");
        if (sb.mismatches == 0 && sb.expected_texels.size() == 0) begin
            $display("tb_texture_sampler_wrap_bilinear_unit: clean");
        end else begin
            $display("tb_texture_sampler_wrap_bilinear_unit: errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/tsw_pkg.sv
rtl/tsw_if.sv
rtl/tsw_ram.sv
rtl/tsw_coord.sv
rtl/tsw_lerp.sv
rtl/texture_sampler_wrap_bilinear_unit.sv
tb/tb_texture_sampler_wrap_bilinear_unit.sv
